// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock, off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/core/efr_pkg.sv -----
// shared types and constants for the ellipse fit residual block
// no dependencies
package efr_pkg;
    localparam int unsigned RES_W = 20;
    localparam logic [19:0] RES_MAX = 20'hFFFFF;
    localparam logic [19:0] RES_ONE = 20'h10000;
    localparam logic [15:0] AXIS_MIN = 16'd32;
    localparam logic [14:0] ANGLE_FULL = 15'd23040;
    localparam logic [14:0] ANGLE_QUARTER = 15'd5760;
    localparam int unsigned CORDIC_STEPS = 18;

    localparam logic [2:0] REG_CX = 3'd0;
    localparam logic [2:0] REG_CY = 3'd1;
    localparam logic [2:0] REG_FW = 3'd2;
    localparam logic [2:0] REG_FH = 3'd3;
    localparam logic [2:0] REG_TILT = 3'd4;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_ANG  = 10'b0000000010,
        S_CORD = 10'b0000000100,
        S_ROT  = 10'b0000001000,
        S_DIVX = 10'b0000010000,
        S_DIVY = 10'b0000100000,
        S_SQ   = 10'b0001000000,
        S_MEAN = 10'b0010000000,
        S_FIN  = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    function automatic logic [22:0] atan_lut(input logic [4:0] i);
        logic [22:0] v;
        begin
            case (i)
                5'd0: v = 23'd2949120;
                5'd1: v = 23'd1740967;
                5'd2: v = 23'd919879;
                5'd3: v = 23'd466945;
                5'd4: v = 23'd234379;
                5'd5: v = 23'd117305;
                5'd6: v = 23'd58666;
                5'd7: v = 23'd29335;
                5'd8: v = 23'd14668;
                5'd9: v = 23'd7334;
                5'd10: v = 23'd3667;
                5'd11: v = 23'd1833;
                5'd12: v = 23'd917;
                5'd13: v = 23'd458;
                5'd14: v = 23'd229;
                5'd15: v = 23'd115;
                5'd16: v = 23'd57;
                5'd17: v = 23'd29;
                default: v = 23'd0;
            endcase
            return v;
        end
    endfunction
endpackage

// ----- rtl/core/efr_if.sv -----
// valid/ready channel interfaces for points and results
// depends on nothing
interface efr_in_if #(parameter int COORD_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  last_point;
    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface efr_out_if;
    logic        valid;
    logic        ready;
    logic [19:0] point_residual;
    logic [19:0] mean_residual;
    logic        mean_valid;
    modport source (output valid, point_residual, mean_residual, mean_valid, input ready);
    modport sink (input valid, point_residual, mean_residual, mean_valid, output ready);
endinterface

// ----- rtl/core/efr_div.sv -----
// shared restoring divider, one quotient bit per cycle
// uses efr_pkg for nothing beyond style; standalone
module efr_div
    import efr_pkg::*;
#(
    parameter int NUM_W = 40,
    parameter int DEN_W = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CW = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] r_q, n_q;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_sub;

    always_comb begin
        w_trial = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
        w_sub = w_trial - {1'b0, r_den};
        n_q = {r_q[NUM_W-2:0], 1'b0};
        n_rem = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_sub;
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q <= n_q;
            r_rem <= n_rem;
        end
    end
    assign o_quot = r_q;
endmodule

// ----- rtl/core/ellipse_fit_residual_top.sv -----
// ellipse residual on one shared divider
// accept to result valid: angle fold, 18 cordic steps, rotate, then two divides in turn
// with handoff, the x and y squares, round, sum and output
// a last point adds a mean divide; a half-axis under one pixel gives a residual of one and skips to the mean step
// next point taken the cycle after the result leaves; no new point is taken while one is in flight
// i_rst_n synchronous active low clears config registers, state, sum, count and handshakes
module ellipse_fit_residual_top
    import efr_pkg::*;
#(
    parameter int MAX_POINTS = 4096,
    parameter int COORD_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    efr_in_if.sink      i_pt,
    efr_out_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SUM_W = CNT_W + 20;
    // offset magnitude, signed offset, product, rotated value and divider widths
    localparam int PX_W = (COORD_BITS > 12) ? COORD_BITS + 4 : 16;
    localparam int DX_W = PX_W + 2;
    localparam int PR_W = DX_W + 19;
    localparam int XR_W = PR_W + 1;
    localparam int DN_W = (PX_W + 24 > SUM_W + 1) ? PX_W + 24 : SUM_W + 1;

    logic [15:0] r_cx, r_cy, r_fw, r_fh;
    logic [14:0] r_tilt;
    t_state r_st;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic r_last;
    logic [1:0] r_quad;
    logic signed [33:0] r_x, r_y;
    logic signed [23:0] r_z;
    logic [4:0] r_i;
    logic signed [18:0] r_c, r_s;
    logic signed [XR_W-1:0] r_xr, r_yr;
    logic [23:0] r_ux, r_uy;
    logic [47:0] r_val;
    logic [19:0] r_res, r_mean;
    logic r_div_go;
    logic r_ovalid;

    logic [2:0] w_reg;
    assign w_reg = paddr[4:2];
    assign pready = 1'b1;

    always_comb begin
        case (w_reg)
            REG_CX: prdata = {16'd0, r_cx};
            REG_CY: prdata = {16'd0, r_cy};
            REG_FW: prdata = {16'd0, r_fw};
            REG_FH: prdata = {16'd0, r_fh};
            REG_TILT: prdata = {17'd0, r_tilt};
            default: prdata = 32'd0;
        endcase
    end

    // divider: numerator |v|<<5 or mean numerator
    logic [DN_W-1:0] r_dnum;
    logic [23:0] r_dden;
    logic w_ddone;
    logic [DN_W-1:0] w_dq;
    efr_div #(.NUM_W(DN_W), .DEN_W(24)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_num(r_dnum), .i_den(r_dden), .o_done(w_ddone), .o_quot(w_dq)
    );

    // cordic step
    logic signed [33:0] w_xs, w_ys;
    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;
    logic signed [23:0] w_at;
    assign w_at = $signed({1'b0, atan_lut(r_i)});

    // rounded cordic outputs
    logic signed [33:0] w_cr, w_sr;
    assign w_cr = (r_x + 34'sd8192) >>> 14;
    assign w_sr = (r_y + 34'sd8192) >>> 14;

    // rotation products, computed in S_ROT as two product pairs in turn
    logic signed [DX_W-1:0] w_dx, w_dy;
    assign w_dx = $signed({2'b0, PX_W'(r_px) << 4}) - $signed({2'b0, PX_W'(r_cx)});
    assign w_dy = $signed({2'b0, PX_W'(r_py) << 4}) - $signed({2'b0, PX_W'(r_cy)});
    logic r_rph;
    logic signed [PR_W-1:0] r_p1, r_p2;

    function automatic logic [XR_W-1:0] mag(input logic signed [XR_W-1:0] v);
        return v[XR_W-1] ? XR_W'(-v) : XR_W'(v);
    endfunction

    logic [47:0] w_one;
    assign w_one = 48'd1 << 40;
    logic [47:0] w_diff;
    assign w_diff = (r_val >= w_one) ? r_val - w_one : w_one - r_val;
    logic [48:0] w_rnd;
    assign w_rnd = ({1'b0, w_diff} + 49'(1 << 23)) >> 24;

    logic r_sqph;
    logic [14:0] w_am;
    assign w_am = (r_tilt >= ANGLE_FULL) ? r_tilt - ANGLE_FULL : r_tilt;

    // one squarer, x ratio then y ratio
    logic [23:0] w_sq_in;
    logic [47:0] w_sq;
    assign w_sq_in = r_sqph ? r_uy : r_ux;
    assign w_sq = w_sq_in * w_sq_in;

    logic [CNT_W-1:0] w_cnt_n;
    logic [SUM_W-1:0] w_sum_n;
    logic w_add;
    assign w_add = r_cnt < CNT_W'(MAX_POINTS);
    assign w_cnt_n = w_add ? r_cnt + 1'b1 : r_cnt;
    assign w_sum_n = w_add ? r_sum + SUM_W'(r_res) : r_sum;

    assign i_pt.ready = (r_st == S_IDLE) && !r_ovalid;
    assign o_res.valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0; r_cy <= '0; r_fw <= '0; r_fh <= '0; r_tilt <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg)
                REG_CX: r_cx <= pwdata[15:0];
                REG_CY: r_cy <= pwdata[15:0];
                REG_FW: r_fw <= pwdata[15:0];
                REG_FH: r_fh <= pwdata[15:0];
                REG_TILT: r_tilt <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_sum <= '0;
            r_cnt <= '0;
            r_ovalid <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (r_ovalid && o_res.ready) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_pt.valid && i_pt.ready) begin
                    r_px <= i_pt.point_x;
                    r_py <= i_pt.point_y;
                    r_last <= i_pt.last_point;
                    r_sqph <= 1'b0;
                    if (r_fw < AXIS_MIN || r_fh < AXIS_MIN) begin
                        r_res <= RES_ONE;
                        r_st <= S_MEAN;
                    end else r_st <= S_ANG;
                end
                S_ANG: begin
                    r_quad <= (w_am >= 3 * ANGLE_QUARTER) ? 2'd3 :
                              (w_am >= 2 * ANGLE_QUARTER) ? 2'd2 :
                              (w_am >= ANGLE_QUARTER) ? 2'd1 : 2'd0;
                    r_z <= 24'((w_am >= 3 * ANGLE_QUARTER) ? w_am - 3 * ANGLE_QUARTER :
                               (w_am >= 2 * ANGLE_QUARTER) ? w_am - 2 * ANGLE_QUARTER :
                               (w_am >= ANGLE_QUARTER) ? w_am - ANGLE_QUARTER : w_am) <<< 10;
                    r_x <= 34'sd652032875;
                    r_y <= '0;
                    r_i <= '0;
                    r_st <= S_CORD;
                end
                S_CORD: begin
                    if (!r_z[23]) begin
                        r_x <= r_x - w_ys; r_y <= r_y + w_xs; r_z <= r_z - w_at;
                    end else begin
                        r_x <= r_x + w_ys; r_y <= r_y - w_xs; r_z <= r_z + w_at;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == 5'(CORDIC_STEPS - 1)) begin
                        r_st <= S_ROT;
                        r_rph <= 1'b0;
                    end
                end
                S_ROT: begin
                    if (!r_rph) begin
                        case (r_quad)
                            2'd1: begin r_c <= -19'(w_sr); r_s <= 19'(w_cr); end
                            2'd2: begin r_c <= -19'(w_cr); r_s <= -19'(w_sr); end
                            2'd3: begin r_c <= 19'(w_sr); r_s <= -19'(w_cr); end
                            default: begin r_c <= 19'(w_cr); r_s <= 19'(w_sr); end
                        endcase
                        r_rph <= 1'b1;
                        r_sqph <= 1'b0;
                    end else if (!r_sqph) begin
                        r_p1 <= r_c * w_dx;
                        r_p2 <= r_s * w_dy;
                        r_sqph <= 1'b1;
                    end else begin
                        r_xr <= XR_W'(r_p1) + XR_W'(r_p2);
                        r_p1 <= r_c * w_dy;
                        r_p2 <= r_s * w_dx;
                        r_st <= S_DIVX;
                        r_sqph <= 1'b0;
                    end
                end
                S_DIVX: begin
                    if (!r_sqph) begin
                        r_yr <= XR_W'(r_p1) - XR_W'(r_p2);
                        r_dnum <= DN_W'(mag(r_xr)) << 5;
                        r_dden <= 24'(r_fw);
                        r_div_go <= 1'b1;
                        r_sqph <= 1'b1;
                    end else if (w_ddone) begin
                        r_ux <= (w_dq > DN_W'(1 << 23)) ? 24'(1 << 23) : w_dq[23:0];
                        r_dnum <= DN_W'(mag(r_yr)) << 5;
                        r_dden <= 24'(r_fh);
                        r_div_go <= 1'b1;
                        r_st <= S_DIVY;
                    end
                end
                S_DIVY: if (w_ddone) begin
                    r_uy <= (w_dq > DN_W'(1 << 23)) ? 24'(1 << 23) : w_dq[23:0];
                    r_st <= S_SQ;
                    r_sqph <= 1'b0;
                end
                S_SQ: begin
                    if (!r_sqph) begin
                        r_val <= w_sq;
                        r_sqph <= 1'b1;
                    end else begin
                        r_val <= r_val + w_sq;
                        r_st <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_res <= (w_rnd > 49'(RES_MAX)) ? RES_MAX : w_rnd[19:0];
                    r_st <= S_MEAN;
                    r_sqph <= 1'b0;
                end
                S_MEAN: begin
                    if (!r_last) begin
                        r_sum <= w_sum_n;
                        r_cnt <= w_cnt_n;
                        r_mean <= '0;
                        r_st <= S_OUT;
                    end else if (!r_sqph) begin
                        r_dnum <= DN_W'(w_sum_n) + DN_W'(w_cnt_n >> 1);
                        r_dden <= 24'(w_cnt_n);
                        r_sqph <= 1'b1;
                        r_div_go <= 1'b1;
                        r_sum <= w_sum_n;
                        r_cnt <= w_cnt_n;
                    end else if (w_ddone) begin
                        r_mean <= (r_cnt == '0) ? 20'd0 :
                                  (w_dq > DN_W'(RES_MAX)) ? RES_MAX : w_dq[19:0];
                        r_sum <= '0;
                        r_cnt <= '0;
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_res.point_residual = r_res;
    assign o_res.mean_residual = r_mean;
    assign o_res.mean_valid = r_last;
endmodule

// ----- rtl/core/efr_checker.sv -----
// port-level checker for the ellipse residual block, bound to the top level
// depends on assert_macros.svh; the bind uses the top level's interface ports
`include "assert_macros.svh"
module efr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [19:0] res,
    input logic [19:0] mean,
    input logic        mean_valid
);
    `ASSERT_IMPLY(a_no_take_while_full, i_clk, i_rst_n, out_valid, !in_ready)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(res))
    `ASSERT_IMPLY(a_mean_zero, i_clk, i_rst_n, out_valid && !mean_valid, mean == 20'd0)
    `ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, in_valid && in_ready, !in_ready)
endmodule

bind ellipse_fit_residual_top efr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_pt.valid), .in_ready(i_pt.ready),
    .out_valid(o_res.valid), .out_ready(o_res.ready),
    .res(o_res.point_residual), .mean(o_res.mean_residual),
    .mean_valid(o_res.mean_valid)
);
